// ----- design/abfsc_pkg.sv -----
// shared types and constants for the allocation bitmap block
`timescale 1ns / 1ps

package abfsc_pkg;

    localparam int BYTE_W    = 8;
    localparam int ROW_BYTES = 8;
    localparam int ROW_BITS  = ROW_BYTES * BYTE_W;

    typedef enum logic [1:0] {
        REQ_FIND  = 2'd0,
        REQ_SET   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_TEST  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0] req_type;
        logic [8:0] position;
        logic       find_value;
    } t_req_item;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] found_position;
        logic       bit_value;
    } t_result;

    typedef struct packed {
        logic    latch;
        logic    clr_wr;
        logic    rd_en;
        logic    rd_pos;
        logic    row_inc;
        logic    wr_mod;
        logic    res_load;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_find;
        logic is_test;
        logic n_zero;
        logic pos_ok;
        logic hit;
        logic scan_last;
        logic clr_last;
    } t_dp_sts;

endpackage

// ----- design/abfsc_dpath.sv -----
// datapath: bitmap memory, row counter, range checks and first-match encoder
`timescale 1ns / 1ps

module abfsc_dpath import abfsc_pkg::*; #(
    parameter int MAP_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  t_req_item  i_item,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    output t_result    o_result
);

    localparam int ROWS = (MAP_BYTES + ROW_BYTES - 1) / ROW_BYTES;
    localparam int RA   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW   = (RA > 3) ? RA : 3;
    localparam int LW   = (RA > 4) ? RA : 4;
    localparam int BW   = (RA + 3 > 7) ? RA + 3 : 7;
    localparam int FW   = (RA + 6 > 9) ? RA + 6 : 9;
    localparam logic [6:0]    CAP      = (MAP_BYTES > 127) ? 7'd127 : 7'(MAP_BYTES);
    localparam logic [RA-1:0] ROW_LAST = RA'(ROWS - 1);

    logic [6:0]          r_cfg;
    t_req_item           r_req;
    logic [RA-1:0]       r_row;
    logic [ROW_BITS-1:0] r_mem [ROWS];
    logic [ROW_BITS-1:0] r_rdata;
    t_result             r_result;
    t_result             n_result;

    logic [6:0]          act_bytes;
    logic [6:0]          act_m1;
    logic [9:0]          lim;
    logic [PW-1:0]       pos_row_ext;
    logic [RA-1:0]       pos_row;
    logic [RA-1:0]       rd_addr;
    logic [RA-1:0]       wr_addr;
    logic [5:0]          bit_ix;
    logic [ROW_BITS-1:0] bit_mask;
    logic [ROW_BITS-1:0] mod_row;
    logic [ROW_BITS-1:0] wr_data;
    logic [ROW_BITS-1:0] cand;
    logic [ROW_BYTES-1:0] byte_ok;
    logic [5:0]          enc;
    logic [FW-1:0]       found_ext;
    logic [LW-1:0]       last_ext;
    logic [LW-1:0]       row_ext;
    logic                wr_en;
    logic                is_find;
    logic                is_test;

    // bytes in use, saturated at the map size
    assign act_bytes = (r_cfg > CAP) ? CAP : r_cfg;
    assign act_m1    = act_bytes - 7'd1;
    assign lim       = {act_bytes, 3'b000};

    assign pos_row_ext = PW'(r_req.position[8:6]);
    assign pos_row     = pos_row_ext[RA-1:0];
    assign bit_ix      = r_req.position[5:0];
    assign bit_mask    = ROW_BITS'(1) << bit_ix;

    assign is_find = (r_req.req_type == REQ_FIND);
    assign is_test = (r_req.req_type == REQ_TEST);

    assign mod_row = (r_req.req_type == REQ_SET) ? (r_rdata | bit_mask)
                                                 : (r_rdata & ~bit_mask);

    assign wr_en   = i_cmd.clr_wr | i_cmd.wr_mod;
    assign wr_addr = i_cmd.clr_wr ? r_row : pos_row;
    assign wr_data = i_cmd.clr_wr ? '0 : mod_row;

    // scan reads the next row while the counter steps
    assign rd_addr = i_cmd.row_inc ? (r_row + RA'(1))
                                   : (i_cmd.rd_pos ? pos_row : r_row);

    always_comb begin
        for (int j = 0; j < ROW_BYTES; j++) begin
            byte_ok[j] = (BW'({r_row, 3'(j)}) < BW'(act_bytes));
        end
        for (int b = 0; b < ROW_BITS; b++) begin
            cand[b] = (r_rdata[b] == r_req.find_value) && byte_ok[b / BYTE_W];
        end
    end

    // lowest matching bit of the current row
    always_comb begin
        enc = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                enc = 6'(b);
            end
        end
    end

    assign found_ext = FW'({r_row, enc});
    assign last_ext  = LW'(act_m1[6:3]);
    assign row_ext   = LW'(r_row);

    always_comb begin
        n_result.status         = i_cmd.res_status;
        n_result.found_position = (is_find && i_cmd.res_status == ST_OK) ?
                                  found_ext[8:0] : 9'd0;
        n_result.bit_value      = (is_test && i_cmd.res_status == ST_OK) ?
                                  r_rdata[bit_ix] : 1'b0;
    end

    assign o_sts.is_find   = is_find;
    assign o_sts.is_test   = is_test;
    assign o_sts.n_zero    = (act_bytes == 7'd0);
    assign o_sts.pos_ok    = ({1'b0, r_req.position} < lim);
    assign o_sts.hit       = |cand;
    assign o_sts.scan_last = (row_ext == last_ext);
    assign o_sts.clr_last  = (r_row == ROW_LAST);

    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 7'd64;
            r_row <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.latch) begin
                r_row <= '0;
            end else if (i_cmd.row_inc) begin
                r_row <= r_row + RA'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_item;
        end
        if (i_cmd.res_load) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_mod |-> (o_sts.pos_ok && !is_find))
        else $error("bitmap write outside the bytes in use");

    a_find_ok_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_load && i_cmd.res_status == ST_OK && is_find) |-> o_sts.hit)
        else $error("find reported success without a match");

endmodule

// ----- design/abfsc_ctrl.sv -----
// controller: clearing pass, request decode, row scan and read-modify-write
`timescale 1ns / 1ps

module abfsc_ctrl import abfsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    output logic    o_strobe,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ACCESS
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_busy;
    logic    r_strobe;
    logic    n_busy;
    t_dp_cmd cmd;

    always_comb begin
        n_state        = r_state;
        cmd            = '0;
        cmd.res_status = ST_OK;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_wr  = 1'b1;
                cmd.row_inc = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_find) begin
                    if (i_sts.n_zero) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_RANGE;
                        n_state        = S_IDLE;
                    end else begin
                        cmd.rd_en = 1'b1;
                        n_state   = S_SCAN;
                    end
                end else if (!i_sts.pos_ok) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_RANGE;
                    n_state        = S_IDLE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_pos = 1'b1;
                    n_state    = S_ACCESS;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    cmd.res_load = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_sts.scan_last) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    n_state        = S_IDLE;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.row_inc = 1'b1;
                end
            end
            S_ACCESS: begin
                cmd.res_load = 1'b1;
                cmd.wr_mod   = !i_sts.is_test;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_busy = (n_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= cmd.res_load;
        end
    end

    assign o_cmd    = cmd;
    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |=> r_busy)
        else $error("busy did not rise after a request was taken");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (!r_busy && r_state == S_IDLE))
        else $error("result word shown while still busy");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.clr_wr && cmd.wr_mod))
        else $error("two memory writes in one cycle");

endmodule

// ----- design/allocation_bitmap_find_set_clear.sv -----
// top level of the allocation bitmap with find-first, set, clear and test
//
// channel   direction  handshake                  payload
// request   in         start high, busy low       i_item (t_req_item)
// result    out        o_strobe, one cycle        o_result (t_result)
// config    in         i_cfg_we                   i_cfg_wdata (bytes in use)
//
// after reset a clearing pass zeroes the bitmap, one 64-bit row a cycle,
// with busy high
// find scans the rows from row 0 up to the match, at most ceil(bytes_in_use/8)
// rows and never past the map; one row of the bitmap memory is read per cycle
// set and clear read the row and write it back modified; test only reads it
// the result word appears in the cycle busy falls; the receiver cannot stall
`timescale 1ns / 1ps

module allocation_bitmap_find_set_clear import abfsc_pkg::*; #(
    parameter int MAP_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req_item  i_item,
    output logic       o_strobe,
    output t_result    o_result,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    abfsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    abfsc_dpath #(
        .MAP_BYTES (MAP_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_result)
    );

endmodule

// ----- dv/abfsc_bitmap_checker.sv -----
// checker that predicts and compares the allocation bitmap results
`timescale 1ns / 1ps

module abfsc_bitmap_checker import abfsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  t_req_item  i_item,
    input  logic       i_strobe,
    input  t_result    i_result,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    output int         o_pending,
    output int         o_compared,
    output int         o_fail_count
);

    localparam int MAP_BYTES = 64;

    logic [BYTE_W-1:0] map_bytes [MAP_BYTES];
    logic [6:0]        bytes_in_use;
    t_result           answers_due [$];
    int                fails = 0;
    int                compared = 0;

    // works out the answer to one request and applies it to the local bitmap
    function automatic t_result bitmap_answer(input t_req_item it);
        t_result r;
        int      n;
        int      pos;
        bit      hit;
        r = '0;
        hit = 1'b0;
        n = (bytes_in_use > MAP_BYTES) ? MAP_BYTES : int'(bytes_in_use);
        pos = int'(it.position);
        if (t_req'(it.req_type) == REQ_FIND) begin
            if (n == 0) begin
                r.status = ST_RANGE;
            end else begin
                r.status = ST_NOT_FOUND;
                // lsb first within a byte, bytes ascending
                for (int p = 0; p < n * BYTE_W && !hit; p++) begin
                    if (map_bytes[p / BYTE_W][p % BYTE_W] == it.find_value) begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.found_position = 9'(p);
                    end
                end
            end
        end else if (pos >= n * BYTE_W) begin
            r.status = ST_RANGE;
        end else begin
            case (t_req'(it.req_type))
                REQ_SET:   map_bytes[pos / BYTE_W][pos % BYTE_W] = 1'b1;
                REQ_CLEAR: map_bytes[pos / BYTE_W][pos % BYTE_W] = 1'b0;
                default:   r.bit_value = map_bytes[pos / BYTE_W][pos % BYTE_W];
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            answers_due.delete();
            bytes_in_use = 7'd64;
            foreach (map_bytes[b]) map_bytes[b] = '0;
        end else begin
            // the result word on the ports belongs to an older request
            if (i_strobe) begin
                if (answers_due.size() == 0) begin
                    $error("result word with no request waiting: status %0d",
                           i_result.status);
                    fails++;
                end else begin
                    want = answers_due.pop_front();
                    compared++;
                    if (i_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, i_result.status);
                        fails++;
                    end
                    if (i_result.found_position !== want.found_position) begin
                        $error("found_position: expected %0d, got %0d",
                               want.found_position, i_result.found_position);
                        fails++;
                    end
                    if (i_result.bit_value !== want.bit_value) begin
                        $error("bit_value: expected %0d, got %0d",
                               want.bit_value, i_result.bit_value);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                answers_due.push_back(bitmap_answer(i_item));
            end
            if (i_cfg_we) begin
                bytes_in_use = i_cfg_wdata;
            end
        end
        o_pending    <= answers_due.size();
        o_compared   <= compared;
        o_fail_count <= fails;
    end

endmodule

// ----- dv/tb_allocation_bitmap_find_set_clear.sv -----
// testbench top: stimulus and verdict for the allocation bitmap block
`timescale 1ns / 1ps

module tb_allocation_bitmap_find_set_clear import abfsc_pkg::*;;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 870;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req_item  i_item;
    logic       o_strobe;
    t_result    o_result;
    logic       i_cfg_we;
    logic [6:0] i_cfg_wdata;

    int         pending;
    int         compared;
    int         fail_count;
    int         idle_cycles = 0;
    int         sent [4] = '{0, 0, 0, 0};
    int         sizes_used = 0;
    logic [6:0] cur_bytes = 7'd64;

    allocation_bitmap_find_set_clear #(
        .MAP_BYTES(64)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    abfsc_bitmap_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_strobe    (o_strobe),
        .i_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (pending),
        .o_compared  (compared),
        .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // a stall with nothing moving means the block has hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** allocation_bitmap_find_set_clear: FAILED **");
            $finish;
        end
    end

    // gap idle cycles, then hold start until the block takes the word
    task automatic issue(input t_req rt, input logic [8:0] pos, input logic fv,
                         input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{req_type: rt, position: pos, find_value: fv};
        while (busy !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
        sent[rt]++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0 || busy !== 1'b0) @(negedge i_clk);
    endtask

    task automatic write_bytes(input logic [6:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        cur_bytes = v;
        sizes_used++;
    endtask

    initial begin
        int   random_done;
        int   phase_len;
        int   eff;
        int   roll;
        int   sel;
        bit   no_gaps;
        bit   set_heavy;
        t_req rt;
        logic [8:0] pos;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        random_done = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty map, scattered bits, full single byte, odd sizes
        write_bytes(7'd64);
        issue(REQ_FIND,  9'd511, 1'b0, 0);
        issue(REQ_FIND,  9'd0,   1'b1, 1);
        issue(REQ_SET,   9'd511, 1'b1, 0);
        issue(REQ_SET,   9'd341, 1'b0, 2);
        issue(REQ_SET,   9'd170, 1'b0, 0);
        issue(REQ_TEST,  9'd511, 1'b0, 0);
        issue(REQ_TEST,  9'd0,   1'b1, 3);
        issue(REQ_FIND,  9'd511, 1'b1, 0);
        issue(REQ_CLEAR, 9'd170, 1'b1, 0);
        issue(REQ_FIND,  9'd0,   1'b1, 0);
        issue(REQ_CLEAR, 9'd511, 1'b0, 6);
        issue(REQ_TEST,  9'd511, 1'b1, 0);
        write_bytes(7'd1);
        issue(REQ_SET,   9'd8,   1'b0, 0);
        for (int b = 0; b < 8; b++) issue(REQ_SET, 9'(b), 1'b0, 0);
        issue(REQ_FIND,  9'd0,   1'b0, 0);
        issue(REQ_TEST,  9'd7,   1'b0, 0);
        write_bytes(7'd0);
        issue(REQ_FIND,  9'd0,   1'b1, 0);
        issue(REQ_CLEAR, 9'd0,   1'b0, 0);
        write_bytes(7'd127);
        issue(REQ_TEST,  9'd341, 1'b0, 0);
        issue(REQ_FIND,  9'd0,   1'b1, 0);

        // random phases, each with its own size, pacing and fill tendency
        while (random_done < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: write_bytes(7'd1);
                1: write_bytes(7'd64);
                2: write_bytes(($urandom_range(0, 2) == 0) ? 7'd0
                               : 7'($urandom_range(65, 127)));
                3, 4, 5: write_bytes(7'($urandom_range(2, 8)));
                default: write_bytes(7'($urandom_range(9, 63)));
            endcase
            eff       = (cur_bytes > 64) ? 64 : int'(cur_bytes);
            phase_len = (eff == 0) ? 10 : $urandom_range(30, 110);
            no_gaps   = ($urandom_range(0, 3) == 0);
            set_heavy = $urandom_range(0, 1);
            for (int i = 0; i < phase_len && random_done < RANDOM_ITEMS; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 20) begin
                    rt = REQ_FIND;
                end else if (roll < (set_heavy ? 65 : 45)) begin
                    rt = REQ_SET;
                end else if (roll < (set_heavy ? 80 : 75)) begin
                    rt = REQ_CLEAR;
                end else begin
                    rt = REQ_TEST;
                end
                if (eff == 0 || $urandom_range(0, 9) == 0) begin
                    pos = 9'($urandom_range(0, 511));
                end else begin
                    pos = 9'($urandom_range(0, eff * 8 - 1));
                end
                issue(rt, pos, 1'($urandom_range(0, 1)),
                      no_gaps ? 0 : $urandom_range(0, 6));
                random_done++;
                if ($urandom_range(0, 59) == 0) drain();
            end
        end

        drain();
        repeat (20) @(negedge i_clk);

        $display("covered %0d requests: %0d find, %0d set, %0d clear, %0d test",
                 sent[REQ_FIND] + sent[REQ_SET] + sent[REQ_CLEAR] + sent[REQ_TEST],
                 sent[REQ_FIND], sent[REQ_SET], sent[REQ_CLEAR], sent[REQ_TEST]);
        $display("%0d bitmap size settings, %0d result words compared",
                 sizes_used, compared);
        if (fail_count == 0 && pending == 0) begin
            $display("** allocation_bitmap_find_set_clear: PASSED **");
        end else begin
            $display("** allocation_bitmap_find_set_clear: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/abfsc_pkg.sv
design/abfsc_dpath.sv
design/abfsc_ctrl.sv
design/allocation_bitmap_find_set_clear.sv
dv/abfsc_bitmap_checker.sv
dv/tb_allocation_bitmap_find_set_clear.sv
